/* hdl/lcfb_pkg.sv */
`default_nettype none

package lcfb_pkg;

    // coordinates are clamped to size minus one and held in three bits
    localparam int COORD_W = 3;
    localparam int CMD_W   = 4;
    localparam int SHAPE_W = 2;

    // default cube geometry
    localparam int DEF_X_SIZE          = 4;
    localparam int DEF_Y_SIZE          = 4;
    localparam int DEF_Z_SIZE          = 4;
    localparam int DEF_BYTES_PER_LAYER = 3;
    localparam int DEF_Z_PIN_BASE      = 16;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR      = 4'd0,
        CMD_FILL       = 4'd1,
        CMD_SET        = 4'd2,
        CMD_CLR_VOXEL  = 4'd3,
        CMD_GET        = 4'd4,
        CMD_LAYER_FULL = 4'd5,
        CMD_REFRESH    = 4'd6,
        CMD_SHIFT_DOWN = 4'd7,
        CMD_DRAW       = 4'd8
    } cmd_t;

    // shape selector for the draw command
    typedef enum logic [SHAPE_W-1:0] {
        SHAPE_WIRE    = 2'd0,
        SHAPE_PLANE_X = 2'd1,
        SHAPE_PLANE_Y = 2'd2,
        SHAPE_PLANE_Z = 2'd3
    } shape_t;

    // which voxel pattern the mask generator builds for the current layer
    typedef enum logic [2:0] {
        MK_POINT,
        MK_ALL,
        MK_WIRE,
        MK_PLANE_X,
        MK_PLANE_Y,
        MK_PLANE_Z
    } mask_kind_t;

    // operation of the shared layer unit
    typedef enum logic [1:0] {
        ALU_KEEP,
        ALU_OR,
        ALU_ANDN,
        ALU_LOAD
    } alu_op_t;

    // test flags from the shared layer unit
    typedef struct packed {
        logic hit;
        logic full;
    } alu_flags_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_EMIT
    } state_t;

    // clamp a coordinate to size minus one
    function automatic logic [COORD_W-1:0] clamp_coord(input logic [7:0] v, input int size);
        logic [COORD_W-1:0] res;
        if (int'(v) >= size)
            res = COORD_W'(size - 1);
        else
            res = v[COORD_W-1:0];
        return res;
    endfunction

endpackage

`default_nettype wire

/* hdl/lcfb_mask_gen.sv */
`default_nettype none

module lcfb_mask_gen #(
    parameter int X_SIZE     = lcfb_pkg::DEF_X_SIZE,
    parameter int Y_SIZE     = lcfb_pkg::DEF_Y_SIZE,
    parameter int Z_SIZE     = lcfb_pkg::DEF_Z_SIZE,
    parameter int Z_PIN_BASE = lcfb_pkg::DEF_Z_PIN_BASE,
    parameter int IMG_W      = 8 * lcfb_pkg::DEF_BYTES_PER_LAYER
) (
    input  wire lcfb_pkg::mask_kind_t             kind,
    input  wire logic [lcfb_pkg::COORD_W-1:0]     x1,
    input  wire logic [lcfb_pkg::COORD_W-1:0]     x2,
    input  wire logic [lcfb_pkg::COORD_W-1:0]     y1,
    input  wire logic [lcfb_pkg::COORD_W-1:0]     y2,
    input  wire logic [lcfb_pkg::COORD_W-1:0]     z1,
    input  wire logic [lcfb_pkg::COORD_W-1:0]     z2,
    input  wire logic [lcfb_pkg::COORD_W-1:0]     z,
    output logic      [IMG_W-1:0]                 mask,
    output logic      [IMG_W-1:0]                 zpin_mask,
    output logic      [IMG_W-1:0]                 fill_word
);
    import lcfb_pkg::*;

    logic zeq1;
    logic zeq2;
    logic zin;

    // position of the current layer relative to the box
    assign zeq1 = (z == z1);
    assign zeq2 = (z == z2);
    assign zin  = (z >= z1) && (z <= z2);

    for (genvar b = 0; b < IMG_W; b++) begin : g_bit
        localparam int BX = b / Y_SIZE;
        localparam int BY = b % Y_SIZE;

        // voxel pattern bits, linear pin mapping x*Y_SIZE+y
        if (b < X_SIZE * Y_SIZE) begin : g_xy
            logic xe1;
            logic xe2;
            logic ye1;
            logic ye2;
            logic xin;
            logic yin;
            logic mask_bit;

            assign xe1 = (x1 == COORD_W'(BX));
            assign xe2 = (x2 == COORD_W'(BX));
            assign ye1 = (y1 == COORD_W'(BY));
            assign ye2 = (y2 == COORD_W'(BY));
            assign xin = (COORD_W'(BX) >= x1) && (COORD_W'(BX) <= x2);
            assign yin = (COORD_W'(BY) >= y1) && (COORD_W'(BY) <= y2);

            always_comb
            begin
                unique case (kind)
                    MK_POINT:   mask_bit = zeq1 && xe1 && ye1;
                    MK_ALL:     mask_bit = zeq1;
                    MK_WIRE:    mask_bit = zin && ((zeq1 || zeq2)
                                    ? ((xin && (ye1 || ye2)) || (yin && (xe1 || xe2)))
                                    : ((xe1 || xe2) && (ye1 || ye2)));
                    MK_PLANE_X: mask_bit = xe1;
                    MK_PLANE_Y: mask_bit = ye1;
                    MK_PLANE_Z: mask_bit = zeq1;
                    default:    mask_bit = 1'b0;
                endcase
            end

            assign mask[b] = mask_bit;
        end else begin : g_no_xy
            assign mask[b] = 1'b0;
        end

        // layer select pins
        if (b >= Z_PIN_BASE && b < Z_PIN_BASE + Z_SIZE) begin : g_pin
            assign zpin_mask[b] = (z1 == COORD_W'(b - Z_PIN_BASE));
            assign fill_word[b] = 1'b0;
        end else begin : g_no_pin
            assign zpin_mask[b] = 1'b0;
            assign fill_word[b] = 1'b1;
        end
    end

endmodule

`default_nettype wire

/* hdl/lcfb_layer_alu.sv */
`default_nettype none

module lcfb_layer_alu #(
    parameter int IMG_W = 8 * lcfb_pkg::DEF_BYTES_PER_LAYER
) (
    input  wire logic [IMG_W-1:0]       word,
    input  wire logic [IMG_W-1:0]       operand,
    input  wire lcfb_pkg::alu_op_t      op,
    output logic      [IMG_W-1:0]       result,
    output lcfb_pkg::alu_flags_t        flags
);
    import lcfb_pkg::*;

    logic [IMG_W-1:0] hits;

    // bitwise update of one layer image
    always_comb
    begin
        unique case (op)
            ALU_KEEP: result = word;
            ALU_OR:   result = word | operand;
            ALU_ANDN: result = word & ~operand;
            ALU_LOAD: result = operand;
            default:  result = word;
        endcase
    end

    // voxel tests against the operand pattern
    assign hits       = word & operand;
    assign flags.hit  = |hits;
    assign flags.full = (hits == operand);

endmodule

`default_nettype wire

/* hdl/led_cube_frame_buffer_core.sv */
`default_nettype none

// Voxel frame buffer for a multiplexed LED cube, one shift-register image per layer.
// A command is taken when start is high and busy is low. The sequencer then walks
// every layer once, one layer per cycle through a single read/write port on the layer
// store and one shared bitwise unit. Refresh then gives BYTES_PER_LAYER result words
// on consecutive cycles, byte 0 first, with last marking the latch; every other
// command gives one word with last high. Results appear for one cycle under strobe
// and cannot be held off; busy falls together with the last result, so the next
// command may be given in that cycle.
module led_cube_frame_buffer_core #(
    parameter int X_SIZE          = lcfb_pkg::DEF_X_SIZE,
    parameter int Y_SIZE          = lcfb_pkg::DEF_Y_SIZE,
    parameter int Z_SIZE          = lcfb_pkg::DEF_Z_SIZE,
    parameter int BYTES_PER_LAYER = lcfb_pkg::DEF_BYTES_PER_LAYER,
    parameter int Z_PIN_BASE      = lcfb_pkg::DEF_Z_PIN_BASE
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [lcfb_pkg::CMD_W-1:0]    cmd,
    input  wire logic [7:0]                    x_first,
    input  wire logic [7:0]                    y_first,
    input  wire logic [7:0]                    z_first,
    input  wire logic [7:0]                    x_second,
    input  wire logic [7:0]                    y_second,
    input  wire logic [7:0]                    z_second,
    input  wire logic [lcfb_pkg::SHAPE_W-1:0]  shape_kind,
    output logic                               strobe,
    output logic [7:0]                         data_byte,
    output logic                               answer_bit,
    output logic                               last
);
    import lcfb_pkg::*;

    localparam int IMG_W = 8 * BYTES_PER_LAYER;
    localparam int ZW    = (Z_SIZE > 1) ? $clog2(Z_SIZE) : 1;
    localparam int BCW   = (BYTES_PER_LAYER > 1) ? $clog2(BYTES_PER_LAYER) : 1;
    localparam bit ALL_XY_FITS = (X_SIZE * Y_SIZE <= IMG_W);

    state_t             state_reg, state_next;
    logic [ZW-1:0]      z_cnt_reg, z_cnt_next;
    logic [BCW-1:0]     byte_cnt_reg, byte_cnt_next;
    cmd_t               cmd_reg, cmd_next;
    shape_t             shape_reg, shape_next;
    logic [COORD_W-1:0] x1_reg, x1_next;
    logic [COORD_W-1:0] x2_reg, x2_next;
    logic [COORD_W-1:0] y1_reg, y1_next;
    logic [COORD_W-1:0] y2_reg, y2_next;
    logic [COORD_W-1:0] z1_reg, z1_next;
    logic [COORD_W-1:0] z2_reg, z2_next;
    logic               answer_reg, answer_next;
    logic [IMG_W-1:0]   img_reg, img_next;
    logic [IMG_W-1:0]   layer_reg [Z_SIZE];
    logic               strobe_reg, strobe_next;
    logic [7:0]         data_byte_reg, data_byte_next;
    logic               answer_bit_reg, answer_bit_next;
    logic               last_reg, last_next;

    logic [COORD_W-1:0] x1_c, x2_c, y1_c, y2_c, z1_c, z2_c;
    logic               accept;
    logic               walk_last;
    logic               zsel;
    logic [ZW-1:0]      rd_idx;
    logic [IMG_W-1:0]   rd_word;
    mask_kind_t         kind;
    logic [IMG_W-1:0]   gen_mask;
    logic [IMG_W-1:0]   zpin_mask;
    logic [IMG_W-1:0]   fill_word;
    alu_op_t            alu_op;
    logic [IMG_W-1:0]   alu_operand;
    logic [IMG_W-1:0]   alu_word;
    alu_flags_t         alu_flags;
    logic               byte_last;

    // clamp coordinates and raise second corners
    always_comb
    begin
        x1_c = clamp_coord(x_first, X_SIZE);
        y1_c = clamp_coord(y_first, Y_SIZE);
        z1_c = clamp_coord(z_first, Z_SIZE);
        x2_c = clamp_coord(x_second, X_SIZE);
        y2_c = clamp_coord(y_second, Y_SIZE);
        z2_c = clamp_coord(z_second, Z_SIZE);
        if (x2_c < x1_c)
            x2_c = x1_c;
        if (y2_c < y1_c)
            y2_c = y1_c;
        if (z2_c < z1_c)
            z2_c = z1_c;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign walk_last = (z_cnt_reg == ZW'(Z_SIZE - 1));
    assign zsel      = (COORD_W'(z_cnt_reg) == z1_reg);
    assign byte_last = (byte_cnt_reg == BCW'(BYTES_PER_LAYER - 1));

    // layer read: shift down takes the layer above
    assign rd_idx  = (cmd_reg == CMD_SHIFT_DOWN && !walk_last) ? z_cnt_reg + ZW'(1) : z_cnt_reg;
    assign rd_word = layer_reg[rd_idx];

    // pattern choice per command
    always_comb
    begin
        unique case (cmd_reg)
            CMD_LAYER_FULL: kind = MK_ALL;
            CMD_DRAW:
            begin
                unique case (shape_reg)
                    SHAPE_WIRE:    kind = MK_WIRE;
                    SHAPE_PLANE_X: kind = MK_PLANE_X;
                    SHAPE_PLANE_Y: kind = MK_PLANE_Y;
                    SHAPE_PLANE_Z: kind = MK_PLANE_Z;
                    default:       kind = MK_WIRE;
                endcase
            end
            default:        kind = MK_POINT;
        endcase
    end

    lcfb_mask_gen #(
        .X_SIZE     (X_SIZE),
        .Y_SIZE     (Y_SIZE),
        .Z_SIZE     (Z_SIZE),
        .Z_PIN_BASE (Z_PIN_BASE),
        .IMG_W      (IMG_W)
    ) u_mask_gen (
        .kind      (kind),
        .x1        (x1_reg),
        .x2        (x2_reg),
        .y1        (y1_reg),
        .y2        (y2_reg),
        .z1        (z1_reg),
        .z2        (z2_reg),
        .z         (COORD_W'(z_cnt_reg)),
        .mask      (gen_mask),
        .zpin_mask (zpin_mask),
        .fill_word (fill_word)
    );

    // operation of the shared unit per command
    always_comb
    begin
        alu_operand = gen_mask;
        unique case (cmd_reg)
            CMD_CLEAR:
            begin
                alu_op      = ALU_LOAD;
                alu_operand = '0;
            end
            CMD_FILL:
            begin
                alu_op      = ALU_LOAD;
                alu_operand = fill_word;
            end
            CMD_SET, CMD_DRAW:  alu_op = ALU_OR;
            CMD_CLR_VOXEL:      alu_op = ALU_ANDN;
            CMD_REFRESH:
            begin
                alu_op      = zsel ? ALU_ANDN : ALU_KEEP;
                alu_operand = zpin_mask;
            end
            CMD_SHIFT_DOWN:
            begin
                alu_op      = walk_last ? ALU_LOAD : ALU_KEEP;
                alu_operand = '0;
            end
            default:            alu_op = ALU_KEEP;
        endcase
    end

    lcfb_layer_alu #(
        .IMG_W (IMG_W)
    ) u_layer_alu (
        .word    (rd_word),
        .operand (alu_operand),
        .op      (alu_op),
        .result  (alu_word),
        .flags   (alu_flags)
    );

    // sequencer: next state and result word
    always_comb
    begin
        state_next      = state_reg;
        z_cnt_next      = z_cnt_reg;
        byte_cnt_next   = byte_cnt_reg;
        cmd_next        = cmd_reg;
        shape_next      = shape_reg;
        x1_next         = x1_reg;
        x2_next         = x2_reg;
        y1_next         = y1_reg;
        y2_next         = y2_reg;
        z1_next         = z1_reg;
        z2_next         = z2_reg;
        answer_next     = answer_reg;
        img_next        = img_reg;
        strobe_next     = 1'b0;
        data_byte_next  = 8'd0;
        answer_bit_next = 1'b0;
        last_next       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next    = ST_WALK;
                    z_cnt_next    = '0;
                    byte_cnt_next = '0;
                    cmd_next      = cmd_t'(cmd);
                    shape_next    = shape_t'(shape_kind);
                    x1_next       = x1_c;
                    x2_next       = x2_c;
                    y1_next       = y1_c;
                    y2_next       = y2_c;
                    z1_next       = z1_c;
                    z2_next       = z2_c;
                    answer_next   = 1'b0;
                end
            end
            ST_WALK:
            begin
                if (zsel)
                begin
                    if (cmd_reg == CMD_GET)
                        answer_next = alu_flags.hit;
                    if (cmd_reg == CMD_LAYER_FULL)
                        answer_next = alu_flags.full && ALL_XY_FITS;
                    if (cmd_reg == CMD_REFRESH)
                        img_next = rd_word | zpin_mask;
                end
                z_cnt_next = z_cnt_reg + ZW'(1);
                if (walk_last)
                begin
                    z_cnt_next = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                strobe_next = 1'b1;
                if (cmd_reg == CMD_REFRESH)
                begin
                    data_byte_next = img_reg[{byte_cnt_reg, 3'b000} +: 8];
                    last_next      = byte_last;
                    byte_cnt_next  = byte_cnt_reg + BCW'(1);
                    if (byte_last)
                        state_next = ST_IDLE;
                end
                else
                begin
                    answer_bit_next = answer_reg;
                    last_next       = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers and layer store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            z_cnt_reg      <= '0;
            byte_cnt_reg   <= '0;
            cmd_reg        <= CMD_CLEAR;
            shape_reg      <= SHAPE_WIRE;
            answer_reg     <= 1'b0;
            strobe_reg     <= 1'b0;
            data_byte_reg  <= 8'd0;
            answer_bit_reg <= 1'b0;
            last_reg       <= 1'b0;
            for (int i = 0; i < Z_SIZE; i++)
                layer_reg[i] <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            z_cnt_reg      <= z_cnt_next;
            byte_cnt_reg   <= byte_cnt_next;
            cmd_reg        <= cmd_next;
            shape_reg      <= shape_next;
            answer_reg     <= answer_next;
            strobe_reg     <= strobe_next;
            data_byte_reg  <= data_byte_next;
            answer_bit_reg <= answer_bit_next;
            last_reg       <= last_next;
            if (state_reg == ST_WALK)
                layer_reg[z_cnt_reg] <= alu_word;
        end
    end

    // coordinate and image payload
    always_ff @(posedge clk)
    begin
        x1_reg  <= x1_next;
        x2_reg  <= x2_next;
        y1_reg  <= y1_next;
        y2_reg  <= y2_next;
        z1_reg  <= z1_next;
        z2_reg  <= z2_next;
        img_reg <= img_next;
    end

    assign strobe     = strobe_reg;
    assign data_byte  = data_byte_reg;
    assign answer_bit = answer_bit_reg;
    assign last       = last_reg;

    // a taken command always starts its walk at the bottom layer
    a_accept_walk: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_WALK) && (z_cnt_reg == '0))
        else $error("command not started at bottom layer");

    // refresh bytes follow each other without gaps
    a_bytes_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last) |=> strobe)
        else $error("gap inside refresh burst");

    // nothing follows the final word of a command straight away
    a_quiet_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |=> !strobe)
        else $error("word right after final word");

    // an answer only comes on a single-word command
    a_answer_single: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && answer_bit) |-> (last && data_byte == 8'd0))
        else $error("answer bit on refresh word");

endmodule

`default_nettype wire
